// ===== sv/clpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// clpwm_pkg
// Shared constants and the pin-pair decode for the charlieplex PWM scanner.
// ----------------------------------------------------------------------------
package clpwm_pkg;

  localparam int LED_COUNT       = 12;
  localparam int INDEX_W         = 4;
  localparam int BRIGHT_W        = 8;
  localparam int PIN_COUNT       = 4;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;
  localparam logic [BRIGHT_W-1:0] SLOT_LAST_RESET = 8'd48;

  // Register indexes (word address = paddr[ADDR_W-1:2])
  localparam logic REG_SLOT_LAST = 1'b0;

  // Request types
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef logic [PIN_COUNT-1:0] pins_t;

  typedef struct packed {
    pins_t enable;
    pins_t level;
  } drive_t;

  // Map an LED index to its pin pair and polarity.
  function automatic drive_t led_drive(input logic [INDEX_W-1:0] idx);
    drive_t d;
    pins_t  a;
    pins_t  b;
    a = '0;
    b = '0;
    case (idx[INDEX_W-1:1])
      3'd0: begin a = 4'b0001; b = 4'b0010; end
      3'd1: begin a = 4'b0010; b = 4'b0100; end
      3'd2: begin a = 4'b0100; b = 4'b1000; end
      3'd3: begin a = 4'b0001; b = 4'b0100; end
      3'd4: begin a = 4'b0010; b = 4'b1000; end
      3'd5: begin a = 4'b0001; b = 4'b1000; end
      default: begin a = '0; b = '0; end
    endcase
    d.enable = a | b;
    d.level  = idx[0] ? a : b;
    return d;
  endfunction

endpackage

// ===== sv/clpwm_ram.sv =====
// ----------------------------------------------------------------------------
// clpwm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/charlieplex_led_pwm_scanner_core.sv =====
// ----------------------------------------------------------------------------
// charlieplex_led_pwm_scanner_core
// PWM scan driver for charlieplexed LEDs on four tristate pins, brightness
// held in a small synchronous RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------
//  in      | sink      | in_valid/in_stall  | req_type, led_index, brightness
//  out     | source    | out_valid/out_stall| pin_drive_enable, pin_drive_level
//  cfg     | APB slave | psel/penable/pready| slot_last at byte address 0
//
//  One request per cycle while the input does not stall; a tick's result passes
//  through the RAM read, then the output register. A write gives no result.
//  The rate is set by the single RAM read port: one tick lookup per cycle.
//  Reset clears the timer, scan position and per-LED valid bits at once, so an
//  LED never written reads as brightness zero; no clearing pass is needed.
//  A stalled output holds its result; input stalls only when the lookup stage
//  is full and the output register is full and stalled.
//
module charlieplex_led_pwm_scanner_core #(
  parameter int LedCount = clpwm_pkg::LED_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [clpwm_pkg::INDEX_W-1:0]  led_index,
  input  logic [clpwm_pkg::BRIGHT_W-1:0] brightness,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output clpwm_pkg::pins_t               pin_drive_enable,
  output clpwm_pkg::pins_t               pin_drive_level,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [clpwm_pkg::ADDR_W-1:0]   paddr,
  input  logic [clpwm_pkg::DATA_W-1:0]   pwdata,
  output logic [clpwm_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  import clpwm_pkg::*;

  localparam int AW = $clog2(LedCount);
  localparam logic [INDEX_W-1:0] LastLed = INDEX_W'(LedCount - 1);
  localparam logic [INDEX_W-1:0] LedLimit = INDEX_W'(LedCount);

  // Configuration register
  logic [BRIGHT_W-1:0] slot_last;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SLOT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_last <= SLOT_LAST_RESET;
    end else if (cfg_wr) begin
      slot_last <= pwdata[BRIGHT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_SLOT_LAST) begin
      prdata = {{(DATA_W-BRIGHT_W){1'b0}}, slot_last};
    end
  end

  // Request decode
  logic in_acc;
  logic tick_acc;
  logic wr_acc;

  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && (req_type == REQ_TICK);
  assign wr_acc   = in_acc && (req_type == REQ_WRITE) && (led_index < LedLimit);

  // Scan counters
  logic [BRIGHT_W-1:0] slot_timer;
  logic [INDEX_W-1:0]  scan_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_timer <= '0;
      scan_pos   <= '0;
    end else if (tick_acc) begin
      if (slot_timer >= slot_last) begin
        // end of slot: restart the timer and advance to the next LED
        slot_timer <= '0;
        scan_pos   <= (scan_pos == LastLed) ? '0 : scan_pos + 1'b1;
      end else begin
        slot_timer <= slot_timer + 1'b1;
      end
    end
  end

  // Per-LED valid bits stand in for clearing the RAM at reset
  logic [LedCount-1:0] store_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
    end else if (wr_acc) begin
      store_valid[led_index[AW-1:0]] <= 1'b1;
    end
  end

  // Brightness store. A write lands at its accept edge, so a tick accepted on
  // the next edge already reads the new value: no forwarding is required.
  logic [BRIGHT_W-1:0] rd_bright;

  clpwm_ram #(
    .WIDTH (BRIGHT_W),
    .DEPTH (LedCount)
  ) u_store (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (led_index[AW-1:0]),
    .wdata (brightness),
    .re    (tick_acc),
    .raddr (scan_pos[AW-1:0]),
    .rdata (rd_bright)
  );

  // Lookup stage: carries the tick's timer and position alongside the RAM read
  logic                s1_valid;
  logic [BRIGHT_W-1:0] s1_timer;
  logic [INDEX_W-1:0]  s1_pos;
  logic                s1_hit;
  logic                out_free;
  logic                s1_move;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_timer <= slot_timer;
      s1_pos   <= scan_pos;
      s1_hit   <= store_valid[scan_pos[AW-1:0]];
    end
  end

  // Compare and drive decode into the output register
  drive_t s1_drive;
  logic   s1_on;

  assign s1_on = s1_hit && (rd_bright > s1_timer);

  always_comb begin
    s1_drive = '0;
    if (s1_on) begin
      s1_drive = led_drive(s1_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pin_drive_enable <= s1_drive.enable;
      pin_drive_level  <= s1_drive.level;
    end
  end

endmodule

// ===== sim/pwm_scan_checker.sv =====
// ----------------------------------------------------------------------------
// pwm_scan_checker
// Watches the request, result and APB channels of the charlieplex scanner,
// keeps its own copy of the brightness table and scan counters, and compares
// every accepted result with the drive pattern predicted for its tick.
// ----------------------------------------------------------------------------
module pwm_scan_checker
  import clpwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                req_type,
  input  logic [INDEX_W-1:0]  led_index,
  input  logic [BRIGHT_W-1:0] brightness,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pins_t               pin_drive_enable,
  input  pins_t               pin_drive_level,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);

  logic [BRIGHT_W-1:0] led_level [LED_COUNT];
  logic [BRIGHT_W-1:0] slot_count;
  logic [BRIGHT_W-1:0] slot_end;
  logic [INDEX_W-1:0]  scan_led;
  drive_t              drive_q [$];

  // Pin pair of one LED: odd index drives the first pin high, even the second.
  function automatic drive_t pair_drive(input int unsigned led);
    drive_t d;
    int     lo;
    int     hi;
    d  = '0;
    lo = 0;
    hi = 0;
    case (led / 2)
      0: begin lo = 0; hi = 1; end
      1: begin lo = 1; hi = 2; end
      2: begin lo = 2; hi = 3; end
      3: begin lo = 0; hi = 2; end
      4: begin lo = 1; hi = 3; end
      5: begin lo = 0; hi = 3; end
      default: return d;
    endcase
    d.enable[lo] = 1'b1;
    d.enable[hi] = 1'b1;
    if (led % 2 == 1) d.level[lo] = 1'b1;
    else d.level[hi] = 1'b1;
    return d;
  endfunction

  // Light the LED under scan if its brightness beats the timer, then advance.
  task automatic scan_tick(output drive_t d);
    d = '0;
    if (scan_led >= LED_COUNT) scan_led = '0;
    if (led_level[scan_led] > slot_count) d = pair_drive(scan_led);
    if (slot_count >= slot_end) begin
      slot_count = '0;
      scan_led   = scan_led + 1'b1;
      if (scan_led >= LED_COUNT) scan_led = '0;
    end else begin
      slot_count = slot_count + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      foreach (led_level[i]) led_level[i] = '0;
      slot_count = '0;
      scan_led   = '0;
      slot_end   = SLOT_LAST_RESET;
      drive_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_SLOT_LAST)
        slot_end = pwdata[BRIGHT_W-1:0];

      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result enable=%h level=%h", $time,
                   pin_drive_enable, pin_drive_level);
        end else begin
          want = drive_q.pop_front();
          if (pin_drive_enable !== want.enable) begin
            fail_count++;
            $display("%0t: pin_drive_enable expected %h actual %h", $time,
                     want.enable, pin_drive_enable);
          end
          if (pin_drive_level !== want.level) begin
            fail_count++;
            $display("%0t: pin_drive_level expected %h actual %h", $time,
                     want.level, pin_drive_level);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (req_type == REQ_WRITE) begin
          if (led_index < LED_COUNT) led_level[led_index] = brightness;
        end else begin
          scan_tick(want);
          drive_q.push_back(want);
        end
      end
    end
    pending = drive_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the charlieplex LED PWM scanner: directed writes
// and ticks around the corner cases, then random request streams over several
// slot lengths with random gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import clpwm_pkg::*;

  localparam int   IDLE_PCT    = 14;
  localparam int   HOLD_CYCLES = 300;
  // A write may still be in flight when the last result arrives, so give it a
  // few spare cycles.
  localparam int   PIPE_SLACK  = 6;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   PHASES      = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                req_type = REQ_TICK;
  logic [INDEX_W-1:0]  led_index = '0;
  logic [BRIGHT_W-1:0] brightness = '0;
  logic                out_valid;
  logic                out_stall;
  pins_t               pin_drive_enable;
  pins_t               pin_drive_level;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int   fail_count;
  int   pending;
  int   cycles = 0;
  // calm: no gaps on either side; want_hold: ask the receiver for one long hold
  logic calm = 1'b0;
  logic want_hold = 1'b0;
  logic hold_taken;

  always #5 clk = ~clk;

  charlieplex_led_pwm_scanner_core u_dut (.*);

  pwm_scan_checker u_checker (.*);

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, none while calm, and one long hold when asked.
  initial begin
    out_stall  = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one request, with random idle cycles first; hold it until accepted.
  task automatic send_req(input logic kind, input logic [INDEX_W-1:0] idx,
                          input logic [BRIGHT_W-1:0] lvl);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    led_index  <= idx;
    brightness <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Ticks carry junk in the ignored fields.
  task automatic send_tick();
    send_req(REQ_TICK, INDEX_W'($urandom_range(15)), BRIGHT_W'($urandom_range(255)));
  endtask

  // Drop valid and wait until every predicted result has been seen.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // APB write of slot_last; upper data bits carry noise the block must drop.
  task automatic write_slot_last(input logic [BRIGHT_W-1:0] value);
    logic [DATA_W-1:0] noise;
    noise = $urandom;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_SLOT_LAST, 2'b00});
    pwdata  <= {noise[DATA_W-1:BRIGHT_W], value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly ticks; writes hit valid LEDs most of the time, out-of-range ones
  // now and then, with brightness at the extremes, up to just past the slot length, or anywhere.
  task automatic send_random(input int write_pct, input logic [BRIGHT_W-1:0] slot);
    logic [INDEX_W-1:0]  idx;
    logic [BRIGHT_W-1:0] lvl;
    int                  top;
    if ($urandom_range(99) >= write_pct) begin
      send_tick();
    end else begin
      if ($urandom_range(99) < 85) idx = INDEX_W'($urandom_range(LED_COUNT - 1));
      else idx = INDEX_W'($urandom_range(15, LED_COUNT));
      top = int'(slot) + 2;
      if (top > 255) top = 255;
      case ($urandom_range(3))
        0: lvl = '0;
        1: lvl = '1;
        2: lvl = BRIGHT_W'($urandom_range(top));
        default: lvl = BRIGHT_W'($urandom_range(255));
      endcase
      send_req(REQ_WRITE, idx, lvl);
    end
  endtask

  initial begin
    logic [BRIGHT_W-1:0] slot;
    int                  count;
    int                  write_pct;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme brightness, zero brightness, out-of-range writes.
    send_req(REQ_WRITE, 4'd0, 8'hFF);
    send_req(REQ_WRITE, 4'd1, 8'd1);
    send_req(REQ_WRITE, 4'd11, 8'h80);
    send_req(REQ_WRITE, 4'd12, 8'h4D);
    send_req(REQ_WRITE, 4'd15, 8'hC3);
    send_req(REQ_WRITE, 4'd2, 8'd0);
    repeat (8) send_tick();
    // Lower the slot end below the running timer: next tick must wrap.
    drain_results();
    write_slot_last(8'd3);
    repeat (4) send_tick();
    // One tick per LED: walk the whole scan once.
    drain_results();
    write_slot_last(8'd0);
    repeat (12) send_tick();

    // Random phases over several slot lengths, extremes included.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: slot = 8'd0;
        1: slot = 8'd255;
        2: slot = 8'd1;
        3: slot = 8'd7;
        4: slot = 8'd3;
        5: slot = BRIGHT_W'($urandom_range(255));
        6: slot = SLOT_LAST_RESET;
        default: slot = 8'd2;
      endcase
      // The longest slot needs 256 ticks to reach its end.
      count     = (slot == 8'd255) ? 320 : 220;
      write_pct = (slot == 8'd255) ? 10 : 22;
      drain_results();
      write_slot_last(slot);
      calm = (p == 2);
      for (int n = 0; n < count; n++) begin
        // Hold the receiver off while requests keep coming, to back up the pipe.
        if (p == 3 && n == 20) want_hold = 1'b1;
        // Pause the sender once until the block has emptied.
        if (p == 4 && n == count / 2) drain_results();
        send_random(write_pct, slot);
      end
      calm = 1'b0;
    end

    drain_results();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
